// ===== rtl/msk_pkg.sv =====
// Shared types, constants and codes of the min-tracking stack.
package msk_pkg;

	localparam int unsigned STACK_DEPTH = 64;
	localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
	localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int unsigned DATA_W      = 32;
	localparam int unsigned OUT_CNT_W   = 7;
	localparam int unsigned ENTRY_W     = 2 * DATA_W;
	localparam int unsigned OUT_TDATA_W = 112;
	localparam int unsigned OUT_USED_W  = 2 + 3 * DATA_W + OUT_CNT_W;

	localparam logic signed [DATA_W-1:0] NONE_VALUE = '1;

	// operation carried in tuser of the input stream
	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_POP_EMPTY = 2'd1,
		STAT_PUSH_FULL = 2'd2,
		STAT_UNUSED    = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP_WAIT
	} state_t;

	// one result item handed from the core to the output register
	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  popped_value;
		logic signed [DATA_W-1:0]  top_value;
		logic signed [DATA_W-1:0]  min_value;
		logic [OUT_CNT_W-1:0]      entry_count;
	} result_t;

endpackage

// ===== rtl/msk_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module msk_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/msk_core.sv =====
// Stack control: top-of-stack registers, fill count, entry memory and sequencer.
module msk_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  msk_pkg::kind_t                       in_kind,
	input  logic signed [msk_pkg::DATA_W-1:0]    in_value,
	output logic                                 in_ready,
	input  logic                                 out_free,
	output logic                                 res_valid,
	output msk_pkg::result_t                     res
);
	import msk_pkg::*;

	state_t                    state_q, state_d;
	logic [CNT_W-1:0]          count_q;
	logic signed [DATA_W-1:0]  top_q;
	logic signed [DATA_W-1:0]  tmin_q;

	logic                      accept;
	logic                      push_ok;
	logic                      pop_deep;
	logic signed [DATA_W-1:0]  push_min;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic                      rd_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic [ENTRY_W-1:0]        rd_data;
	logic signed [DATA_W-1:0]  rd_value;
	logic signed [DATA_W-1:0]  rd_min;

	// entry memory: {level minimum, value} per level
	msk_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({push_min, in_value}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_value = rd_data[DATA_W-1:0];
	assign rd_min   = rd_data[ENTRY_W-1:DATA_W];

	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign push_ok  = (in_kind == KIND_PUSH) && (count_q < CNT_W'(STACK_DEPTH));
	assign pop_deep = (in_kind == KIND_POP) && (count_q > CNT_W'(1));

	// running minimum of the new level
	assign push_min = ((count_q != '0) && (tmin_q < in_value)) ? tmin_q : in_value;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && pop_deep) begin
					state_d = ST_POP_WAIT;
				end
			end
			ST_POP_WAIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory access and result
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[ADDR_W-1:0];
		rd_en   = 1'b0;
		rd_addr = ADDR_W'(count_q - CNT_W'(2));
		res_valid          = 1'b0;
		res.status         = STAT_DONE;
		res.popped_value   = NONE_VALUE;
		res.top_value      = top_q;
		res.min_value      = tmin_q;
		res.entry_count    = OUT_CNT_W'(count_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_kind == KIND_PUSH) begin
						res_valid = 1'b1;
						if (push_ok) begin
							wr_en           = 1'b1;
							res.top_value   = in_value;
							res.min_value   = push_min;
							res.entry_count = OUT_CNT_W'(count_q + CNT_W'(1));
						end else begin
							res.status = STAT_PUSH_FULL;
						end
					end else if (pop_deep) begin
						rd_en = 1'b1;
					end else begin
						res_valid       = 1'b1;
						res.top_value   = NONE_VALUE;
						res.min_value   = NONE_VALUE;
						res.entry_count = '0;
						if (count_q == '0) begin
							res.status = STAT_POP_EMPTY;
						end else begin
							res.popped_value = top_q;
						end
					end
				end
			end
			ST_POP_WAIT: begin
				res_valid        = 1'b1;
				res.popped_value = top_q;
				res.top_value    = rd_value;
				res.min_value    = rd_min;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// hold state and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && push_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (accept && (in_kind == KIND_POP) && (count_q != '0)) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// hold the top entry so pushes and shallow pops never wait on the memory
	always_ff @(posedge clk) begin
		if (accept && push_ok) begin
			top_q  <= in_value;
			tmin_q <= push_min;
		end else if (state_q == ST_POP_WAIT) begin
			top_q  <= rd_value;
			tmin_q <= rd_min;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("fill count above stack depth");

	a_wait_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_WAIT) |-> (count_q != '0))
		else $error("memory read pending with empty stack");

	a_wait_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP_WAIT) |=> (state_q == ST_IDLE))
		else $error("pop read held longer than one cycle");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_free)
		else $error("result produced with output register occupied");

	a_min_le_top: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (tmin_q <= top_q))
		else $error("level minimum above top value");

endmodule

// ===== rtl/min_tracking_stack_unit.sv =====
// Top level of the min-tracking stack: stream ports, core and output register.
// Results: pushes and pops on a stack of one entry or none give their result in the cycle
// after the transfer; other pops first pass the registered memory read and ST_POP_WAIT.
// Throughput: one push per cycle while the output register is free; pops on two or more
// entries block input in ST_POP_WAIT; an item may enter the output as a result drains.
// Reset: arst_n empties the stack and the output register; the memory is not cleared.
module min_tracking_stack_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [31:0]                          s_tdata,  // [31:0] push_value
	input  logic                                 s_tuser,  // [0] kind
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [msk_pkg::OUT_TDATA_W-1:0]      m_tdata   // [1:0] status,
	// [33:2] popped_value, [65:34] top_value, [97:66] min_value,
	// [104:98] entry_count, rest zero
);
	import msk_pkg::*;

	logic     out_free;
	logic     res_valid;
	result_t  res;
	logic     m_valid_q;
	result_t  res_q;

	assign out_free = !m_valid_q || m_tready;

	msk_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_kind   (kind_t'(s_tuser)),
		.in_value  ($signed(s_tdata)),
		.in_ready  (s_tready),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {
		(OUT_TDATA_W - OUT_USED_W)'(0),
		res_q.entry_count,
		res_q.min_value,
		res_q.top_value,
		res_q.popped_value,
		res_q.status
	};

endmodule

// ===== tb/tb_min_tracking_stack_unit.sv =====
// Self-checking testbench for the min-tracking stack: stream stimulus, shadow stack, result check.
`timescale 1ns / 100ps

module tb_min_tracking_stack_unit;
	import msk_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 5;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 200;
	localparam int TAIL_CYCLES  = 8;
	localparam int MAX_REPORTS  = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [31:0]            s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// shadow copy of the stack and the per-level running minimum
	logic signed [DATA_W-1:0] shadow_vals [STACK_DEPTH];
	logic signed [DATA_W-1:0] shadow_mins [STACK_DEPTH];
	int unsigned              shadow_fill;

	result_t pending_results[$];

	int  err_count;
	int  mismatch_count;
	bit  tx_idle_en;
	bit  rx_idle_en;
	bit  rx_hold_req;

	min_tracking_stack_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// free-running clock
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// watchdog: end the run with an error at the cycle limit
	initial begin
		int cycle_cnt;
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// work out the result of one accepted operation and queue it
	function automatic void predict_stack_op(kind_t k, logic signed [DATA_W-1:0] v);
		result_t r;
		logic signed [DATA_W-1:0] m;
		r.status       = STAT_DONE;
		r.popped_value = NONE_VALUE;
		r.top_value    = NONE_VALUE;
		r.min_value    = NONE_VALUE;
		if (k == KIND_PUSH) begin
			if (shadow_fill >= STACK_DEPTH) begin
				r.status = STAT_PUSH_FULL;
			end else begin
				m = v;
				if (shadow_fill > 0 && shadow_mins[shadow_fill-1] < v)
					m = shadow_mins[shadow_fill-1];
				shadow_vals[shadow_fill] = v;
				shadow_mins[shadow_fill] = m;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				r.status = STAT_POP_EMPTY;
			end else begin
				shadow_fill--;
				r.popped_value = shadow_vals[shadow_fill];
			end
		end
		if (shadow_fill > 0) begin
			r.top_value = shadow_vals[shadow_fill-1];
			r.min_value = shadow_mins[shadow_fill-1];
		end
		r.entry_count = OUT_CNT_W'(shadow_fill);
		pending_results.push_back(r);
	endfunction

	function automatic void compare_field(string fname, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_count++;
			mismatch_count++;
			if (mismatch_count <= MAX_REPORTS)
				$display("mismatch on %s: expected %h, got %h", fname, want, got);
		end
	endfunction

	// check every result transfer against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("result with no prediction pending: %h", m_tdata);
			end else begin
				want = pending_results.pop_front();
				compare_field("status",       32'(want.status),      32'(m_tdata[1:0]));
				compare_field("popped_value", want.popped_value,     m_tdata[33:2]);
				compare_field("top_value",    want.top_value,        m_tdata[65:34]);
				compare_field("min_value",    want.min_value,        m_tdata[97:66]);
				compare_field("entry_count",  32'(want.entry_count), 32'(m_tdata[104:98]));
			end
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_tready    <= 1'b0;
				rx_hold_req = 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// offer one operation, wait for its transfer, then predict it
	task automatic send_op(kind_t k, logic signed [DATA_W-1:0] v);
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		predict_stack_op(k, v);
	endtask

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return NONE_VALUE;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	task automatic run_random_ops(int n, int push_pct);
		kind_t k;
		for (int i = 0; i < n; i++) begin
			k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
			send_op(k, rand_value());
		end
	endtask

	// extremes, equal minimum values, pops on an empty stack
	task automatic test_directed();
		send_op(KIND_POP,  32'sd0);
		send_op(KIND_POP,  NONE_VALUE);
		send_op(KIND_PUSH, 32'sh7FFF_FFFF);
		send_op(KIND_PUSH, 32'sh8000_0000);
		send_op(KIND_PUSH, 32'sh8000_0000);
		send_op(KIND_PUSH, 32'sd0);
		send_op(KIND_PUSH, NONE_VALUE);
		send_op(KIND_PUSH, 32'sd5);
		repeat (6) send_op(KIND_POP, 32'sh7FFF_FFFF);
		send_op(KIND_POP,  32'sd0);
		send_op(KIND_PUSH, -32'sd5);
		send_op(KIND_PUSH, 32'sd3);
		send_op(KIND_PUSH, -32'sd5);
		send_op(KIND_POP,  32'sd0);
		send_op(KIND_POP,  32'sd0);
		send_op(KIND_POP,  32'sd0);
	endtask

	// mostly pushes: reach the full stack and rejected pushes
	task automatic test_fill_to_full();
		run_random_ops(150, 85);
	endtask

	// mostly pops: empty the stack and pop past the bottom
	task automatic test_drain_to_empty();
		run_random_ops(150, 15);
	endtask

	task automatic test_random_walk();
		run_random_ops(150, 50);
	endtask

	// hold the result side off while items keep coming
	task automatic test_output_stall();
		rx_hold_req = 1'b1;
		run_random_ops(30, 60);
	endtask

	// back-to-back transfers with no idling on either side
	task automatic test_full_rate();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_random_ops(120, 55);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = 1'b0;
		shadow_fill    = 0;
		err_count      = 0;
		mismatch_count = 0;
		tx_idle_en     = 1'b1;
		rx_idle_en     = 1'b1;
		rx_hold_req    = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_to_full();
		test_drain_to_empty();
		test_random_walk();
		test_output_stall();
		test_full_rate();

		// stop offering, let every result drain, then a few cycles more
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
